/* sv/keyed_block_word_generator_top_assert.svh */
// Assertion macros used by the keyed block word generator RTL.
// Included by kbwg_core, which carries the concurrent checks; depends on nothing.
`ifndef KEYED_BLOCK_WORD_GENERATOR_TOP_ASSERT_SVH
`define KEYED_BLOCK_WORD_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KBWG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KBWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/kbwg_pkg.sv */
// Shared constants, types and helper functions of the keyed block word generator.
// No dependencies; used by kbwg_mul, kbwg_core and the top level.
package kbwg_pkg;

   localparam int WORD_W = 32;
   localparam int STEP_W = 8;
   localparam int BLOCK_WORDS_DEF = 255;

   localparam logic [WORD_W-1:0] MUL_M   = 32'h06a0dd9b;
   localparam logic [WORD_W-1:0] WEYL    = 32'h9E3779B9;
   localparam logic [WORD_W-1:0] FMIX_C1 = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] FMIX_C2 = 32'hc2b2ae35;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last_in_block;
   } kbwg_rsp_type;

   // Rotate left; an amount of zero returns the input unchanged.
   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input logic [4:0] r);
      logic [2*WORD_W-1:0] t;
      t = {v, v} << r;
      return t[2*WORD_W-1:WORD_W];
   endfunction

endpackage

/* sv/kbwg_mul.sv */
// Shared 32x32 multiplier (low half of the product) with a registered result.
// Depends on kbwg_pkg.
module kbwg_mul (
   input  logic                         clock,
   input  logic [kbwg_pkg::WORD_W-1:0]  mul_a,
   input  logic [kbwg_pkg::WORD_W-1:0]  mul_b,
   output logic [kbwg_pkg::WORD_W-1:0]  mul_p
);
   import kbwg_pkg::*;

   logic [WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

/* sv/kbwg_core.sv */
// Sequencer and datapath of the keyed block word generator: chain state, plus
// block-start mixing and table entries through one shared multiplier.
// Depends on kbwg_pkg, kbwg_mul and keyed_block_word_generator_top_assert.svh.
`include "keyed_block_word_generator_top_assert.svh"

module kbwg_core #(
   parameter int BLOCK_WORDS = kbwg_pkg::BLOCK_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         restart,
   input  logic [kbwg_pkg::WORD_W-1:0]  seed_key,
   input  logic                         out_free,
   output logic                         idle,
   output logic                         done,
   output kbwg_pkg::kbwg_rsp_type       rsp
);
   import kbwg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_KEY, S_FM1, S_FM2, S_FM3, S_T6, S_T7, S_AB, S_ROT
   } state_type;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [WORD_W-1:0] key_offset_ff, key_offset_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] mix_ff, mix_in;
   logic [WORD_W-1:0] chain_a_ff, chain_a_in;
   logic [7:0]        chain_d_ff, chain_d_in;
   logic [WORD_W-1:0] o_ff, o_in;
   logic [4:0]        b_ff, b_in;

   logic [WORD_W-1:0] mul_a, mul_b, mul_p;
   logic [STEP_W-1:0] i_idx, j6, j7, j_sel;
   logic [WORD_W-1:0] entry, a_val, b_val, c_val, d_ext;
   logic              last;
   logic              fire;

   kbwg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign i_idx = STEP_W'(8'hFF) - step_ff;
   assign j6    = i_idx + STEP_W'(6);
   assign j7    = i_idx + STEP_W'(7);
   assign j_sel = (state_ff == S_T6) ? j6 : j7;
   assign entry = rotl32(mul_p + mix_ff, key_ff[4:0] ^ j_sel[4:0]);

   assign d_ext = {{(WORD_W-8){1'b0}}, chain_d_ff};
   assign a_val = (d_ext ^ o_ff) ^ (key_ff + chain_a_ff);
   assign b_val = (key_ff + a_val) ^ (o_ff + d_ext);
   assign c_val = rotl32((chain_a_ff >> 13) ^ chain_a_ff, b_ff);

   assign last = ({1'b0, step_ff} + (STEP_W+1)'(1)) >= (STEP_W+1)'(BLOCK_WORDS);
   assign fire = (state_ff == S_ROT) && out_free;

   // Operand select for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = MUL_M;
      case (state_ff)
         S_KEY: begin
            mul_a = (step_ff == '0) ? key_ff : WORD_W'(j6);
         end
         S_FM1: begin
            mul_a = mul_p ^ (mul_p >> 16);
            mul_b = FMIX_C1;
         end
         S_FM2: begin
            mul_a = mul_p ^ (mul_p >> 13);
            mul_b = FMIX_C2;
         end
         S_FM3: mul_a = WORD_W'(j6);
         S_T6:  mul_a = WORD_W'(j7);
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      key_offset_in = key_offset_ff;
      step_in       = step_ff;
      mix_in        = mix_ff;
      chain_a_in    = chain_a_ff;
      chain_d_in    = chain_d_ff;
      o_in          = o_ff;
      b_in          = b_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Restart drops back to the head of block zero.
               if (restart) begin
                  key_offset_in = '0;
                  step_in       = '0;
                  key_in        = seed_key;
               end else begin
                  key_in        = seed_key + key_offset_ff;
               end
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            if (step_ff == '0) begin
               chain_a_in = key_ff;
               chain_d_in = '0;
               state_in   = S_FM1;
            end else begin
               state_in   = S_T6;
            end
         end
         S_FM1: state_in = S_FM2;
         S_FM2: state_in = S_FM3;
         S_FM3: begin
            mix_in   = mul_p ^ (mul_p >> 16);
            state_in = S_T6;
         end
         S_T6: begin
            o_in     = entry << 6;
            state_in = S_T7;
         end
         S_T7: begin
            o_in     = o_ff ^ (entry << 7);
            state_in = S_AB;
         end
         S_AB: begin
            chain_a_in = a_val;
            b_in       = b_val[4:0];
            state_in   = S_ROT;
         end
         S_ROT: begin
            // Hold until the output register can take the word.
            if (out_free) begin
               chain_d_in = c_val[7:0];
               if (last) begin
                  step_in       = '0;
                  key_offset_in = key_offset_ff + WEYL;
               end else begin
                  step_in       = step_ff + STEP_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         key_offset_ff <= '0;
         step_ff       <= '0;
         chain_a_ff    <= '0;
         chain_d_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         key_offset_ff <= key_offset_in;
         step_ff       <= step_in;
         chain_a_ff    <= chain_a_in;
         chain_d_ff    <= chain_d_in;
      end
      key_ff <= key_in;
      mix_ff <= mix_in;
      o_ff   <= o_in;
      b_ff   <= b_in;
   end

   assign idle              = (state_ff == S_IDLE);
   assign done              = fire;
   assign rsp.word          = c_val;
   assign rsp.last_in_block = last;

   `KBWG_ASSERT_IMPL(a_start_when_idle, clock, reset, start, state_ff == S_IDLE,
      "transaction accepted while core busy")
   `KBWG_ASSERT_NEXT(a_block_start_mix, clock, reset,
      (state_ff == S_KEY) && (step_ff == '0), state_ff == S_FM1,
      "block start skipped offset mixing")
   `KBWG_ASSERT_NEXT(a_stall_holds_chain, clock, reset,
      (state_ff == S_ROT) && !out_free,
      (state_ff == S_ROT) && $stable(chain_a_ff) && $stable(step_ff),
      "chain state moved while output stalled")
   `KBWG_ASSERT_IMPL(a_step_in_block, clock, reset, 1'b1,
      {1'b0, step_ff} < (STEP_W+1)'(BLOCK_WORDS),
      "step index beyond block length")

endmodule

/* sv/keyed_block_word_generator_top.sv */
// Keyed block word generator: one pseudo-random 32-bit word per request
// transaction, generated in blocks of BLOCK_WORDS words with a Weyl-stepped key.
// Depends on kbwg_pkg and kbwg_core.
//
// req channel: one transaction per word; req_tdata[0] = restart, which returns
//   the stream to the start of block zero before this word.
// rsp channel: rsp_tdata = word, rsp_tlast = last word of its block.
// csr port: csr_wr_en writes csr_wr_data into the base key (key of block zero);
//   write it only while no transaction is in flight.
// A request passes KEY, T6, T7, AB and ROT, then the output register; the first
//   word of a block adds three passes through the offset mixer.
// A new request is taken only once the last word is done; the single shared
//   multiplier is used twice per word for the table entries, three more times
//   for the block offset.
// req_tready is high only while the core is idle. A finished word sits in the
//   output register, and the next request may be accepted while it waits.
// When the output register is full and rsp_tready is low, the core holds its finished word and state.
// Reset clears the base key, block counter and position: the next word starts
//   block zero.
module keyed_block_word_generator_top #(
   parameter int BLOCK_WORDS = kbwg_pkg::BLOCK_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,    // [0] restart, [7:1] zero
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [kbwg_pkg::WORD_W-1:0]  rsp_tdata,    // [31:0] word
   output logic                         rsp_tlast,
   input  logic                         csr_wr_en,
   input  logic [kbwg_pkg::WORD_W-1:0]  csr_wr_data
);
   import kbwg_pkg::*;

   logic [WORD_W-1:0] seed_key_ff, seed_key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              core_idle;
   logic              core_done;
   logic              out_free;
   logic              start;
   kbwg_rsp_type      core_rsp;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = core_idle;
   assign start      = req_tvalid && core_idle;

   kbwg_core #(
      .BLOCK_WORDS (BLOCK_WORDS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .restart  (req_tdata[0]),
      .seed_key (seed_key_ff),
      .out_free (out_free),
      .idle     (core_idle),
      .done     (core_done),
      .rsp      (core_rsp)
   );

   always_comb begin
      seed_key_in  = csr_wr_en ? csr_wr_data : seed_key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = core_rsp.word;
         rsp_last_in  = core_rsp.last_in_block;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_key_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_key_ff  <= seed_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
